[rtl/audition_gate_gain_ramp_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the audition gate gain ramp
// Concurrent checks clocked on clk; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef AUDITION_GATE_GAIN_RAMP_DEFINES_SVH
`define AUDITION_GATE_GAIN_RAMP_DEFINES_SVH
`ifndef ASSERT_OFF
`define AGR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AGR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AGR_ASSERT(lbl, prop, msg)
`define AGR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/agr_pkg.sv]
// ----------------------------------------------------------------------------
// agr_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package agr_pkg;

    localparam int SOURCES   = 16;
    localparam int SRC_W     = $clog2(SOURCES);
    localparam int HOLD_MAX  = 64;
    localparam int DIV_W     = 24;
    localparam int DIV_CNT_W = 5;
    localparam logic [15:0] RAMP_RESET = 16'd144;
    localparam logic signed [24:0] UNITY_Q = 25'sd8388608;

    typedef enum logic [1:0] {
        OP_QUERY   = 2'd0,
        OP_RETAIN  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_EXTEND  = 2'd3
    } agr_op_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic update;
        logic elap;
        logic mul;
        logic acc;
        logic goal_set;
        logic div_step;
        logic step_set;
        logic store;
        logic out_load;
    } agr_cmd_t;

    typedef struct packed {
        logic id_ok;
        logic is_query;
        logic goal_change;
        logic div_done;
        logic out_free;
    } agr_status_t;

endpackage

[rtl/audition_gate_gain_ramp.sv]
// ----------------------------------------------------------------------------
// audition_gate_gain_ramp
// Per-source audition gate with hold count, deadline and linear gain ramp.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with operation, source_index,
//   query_frame, render_frame and span_frames. Retain, release and extend
//   only update the gate; a gain query on a valid source returns one gain
//   (Q1.23, 0..1.0) on out_valid/out_stall. Out-of-range sources are dropped.
//   Steps per request: retain, release, extend or an invalid source pass
//   through accept and load only. A query runs accept, load, elapsed
//   frames, multiply, accumulate, target check and store when the target
//   holds; when it changes, a restoring divider runs before store, one
//   quotient bit per cycle over 24 bits, and then sets the step. One request is in
//   flight at a time; in_stall is high from acceptance until back at idle.
//   The ramp length is written through cfg_write_enable/cfg_write_data;
//   write it only while idle. A value of 0 acts as 1.
//   Reset clears all gates and sets the ramp length to 144; no clearing pass.
//   A stalled result is held in the output register; the next request is
//   still taken, and a further query waits in its store step until the
//   output register frees.
// ----------------------------------------------------------------------------
`include "audition_gate_gain_ramp_defines.svh"

module audition_gate_gain_ramp
    import agr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [4:0]  source_index,
    input  logic [47:0] query_frame,
    input  logic [47:0] render_frame,
    input  logic [21:0] span_frames,
    input  logic        cfg_write_enable,
    input  logic [15:0] cfg_write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] gain
);

    agr_cmd_t    cmd;
    agr_status_t st;

    // sequencer
    agr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // gate state and arithmetic
    agr_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .operation        (operation),
        .source_index     (source_index),
        .query_frame      (query_frame),
        .render_frame     (render_frame),
        .span_frames      (span_frames),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .gain             (gain)
    );

    // an accepted request always keeps the block busy next cycle
    `AGR_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "not busy after accept")
    // a result is only loaded when the output register is free
    `AGR_ASSERT(a_load_when_free, cmd.out_load |-> (!out_valid || !out_stall), "result overwritten")
    // gain is clamped to unity
    `AGR_ASSERT(a_gain_clamped, out_valid |-> (gain <= 24'd8388608), "gain above unity")
    // divider only steps while a count remains
    `AGR_ASSERT(a_div_bounded, cmd.div_step |-> !st.div_done, "divider overrun")

endmodule

[rtl/agr_ctrl.sv]
// ----------------------------------------------------------------------------
// agr_ctrl
// Sequencer for one request at a time: load, advance, retarget, divide, store.
// ----------------------------------------------------------------------------
module agr_ctrl
    import agr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  agr_status_t st,
    output agr_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_ELAP  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_GOAL  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_STORE = 8'b1000_0000
    } agr_state_t;

    agr_state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.load = 1'b1;
                if (!st.id_ok)
                    state_next = S_IDLE;
                else if (!st.is_query)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_ELAP;
            end
            S_ELAP:
            begin
                cmd.elap   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_GOAL;
            end
            S_GOAL:
            begin
                if (st.goal_change)
                begin
                    cmd.goal_set = 1'b1;
                    state_next   = S_DIV;
                end
                else
                    state_next = S_STORE;
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.step_set = 1'b1;
                    state_next   = S_STORE;
                end
                else
                    cmd.div_step = 1'b1;
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/agr_datapath.sv]
// ----------------------------------------------------------------------------
// agr_datapath
// Per-source gate state, ramp arithmetic, step divider and result register.
// ----------------------------------------------------------------------------
module agr_datapath
    import agr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  agr_cmd_t    cmd,
    output agr_status_t st,
    input  logic [1:0]  operation,
    input  logic [4:0]  source_index,
    input  logic [47:0] query_frame,
    input  logic [47:0] render_frame,
    input  logic [21:0] span_frames,
    input  logic        cfg_write_enable,
    input  logic [15:0] cfg_write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] gain
);

    // latched request
    logic [1:0]  op_reg;
    logic [4:0]  id_reg;
    logic [47:0] qf_reg, render_reg;
    logic [21:0] span_reg;
    logic [15:0] ramp_reg;

    // per-source state
    logic signed [24:0] level_mem [SOURCES];
    logic               goal_mem  [SOURCES];
    logic signed [24:0] step_mem  [SOURCES];
    logic [15:0]        left_mem  [SOURCES];
    logic [47:0]        mark_mem  [SOURCES];
    logic [47:0]        dead_mem  [SOURCES];
    logic [6:0]         hold_mem  [SOURCES];

    // working copy of the addressed gate
    logic signed [24:0] w_level_reg, w_step_reg;
    logic               w_goal_reg;
    logic [15:0]        w_left_reg, el_reg;
    logic [47:0]        w_mark_reg;
    logic               adv_reg;
    logic signed [41:0] prod_reg;

    // step divider
    logic [DIV_W-1:0]     div_q_reg;
    logic [15:0]          div_rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 div_neg_reg;

    logic               out_valid_reg;
    logic [23:0]        gain_reg;

    logic [SRC_W-1:0]   sidx;
    logic [15:0]        rf;
    logic [48:0]        until_sum;
    logic [47:0]        until_sat;
    logic [6:0]         hold_dec;
    logic [47:0]        el_diff;
    logic [15:0]        left_new;
    logic               goal_new;
    logic signed [24:0] num;
    logic [24:0]        num_mag;
    logic [16:0]        rem_sh;
    logic [23:0]        clamped;

    assign sidx = SRC_W'(id_reg - 5'd1);
    assign rf   = (ramp_reg == 16'd0) ? 16'd1 : ramp_reg;

    assign until_sum = {1'b0, render_reg} + {27'd0, span_reg};
    assign until_sat = until_sum[48] ? {48{1'b1}} : until_sum[47:0];
    assign hold_dec  = (hold_mem[sidx] != 7'd0) ? hold_mem[sidx] - 7'd1 : 7'd0;
    assign el_diff   = qf_reg - w_mark_reg;
    assign left_new  = w_left_reg - el_reg;
    assign goal_new  = (hold_mem[sidx] != 7'd0) || (qf_reg < dead_mem[sidx]);
    assign num       = (goal_new ? UNITY_Q : 25'sd0) - w_level_reg;
    assign num_mag   = num[24] ? 25'(-num) : 25'(num);
    assign rem_sh    = {div_rem_reg, div_q_reg[DIV_W-1]};

    always_comb
    begin
        if (w_level_reg < 25'sd0)
            clamped = 24'd0;
        else if (w_level_reg > UNITY_Q)
            clamped = UNITY_Q[23:0];
        else
            clamped = w_level_reg[23:0];
    end

    assign st.id_ok       = (id_reg != 5'd0) && (id_reg <= 5'(SOURCES));
    assign st.is_query    = (op_reg == OP_QUERY);
    assign st.goal_change = (goal_new != w_goal_reg);
    assign st.div_done    = (div_cnt_reg == '0);
    assign st.out_free    = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign gain      = gain_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= operation;
            id_reg     <= source_index;
            qf_reg     <= query_frame;
            render_reg <= render_frame;
            span_reg   <= span_frames;
        end
        if (cmd.load)
        begin
            w_level_reg <= level_mem[sidx];
            w_goal_reg  <= goal_mem[sidx];
            w_step_reg  <= step_mem[sidx];
            w_left_reg  <= left_mem[sidx];
            // unset mark picks up the render position
            if (mark_mem[sidx] == 48'd0 && render_reg != 48'd0)
                w_mark_reg <= render_reg;
            else
                w_mark_reg <= mark_mem[sidx];
        end
        if (cmd.elap)
        begin
            adv_reg <= (qf_reg > w_mark_reg) && (w_left_reg != 16'd0);
            el_reg  <= (el_diff > {32'd0, w_left_reg}) ? w_left_reg : el_diff[15:0];
        end
        if (cmd.mul)
            prod_reg <= w_step_reg * $signed({1'b0, el_reg});
        if (cmd.acc && adv_reg)
        begin
            w_left_reg <= left_new;
            w_mark_reg <= w_mark_reg + {32'd0, el_reg};
            if (left_new == 16'd0)
            begin
                w_level_reg <= w_goal_reg ? UNITY_Q : 25'sd0;
                w_step_reg  <= 25'sd0;
            end
            else
                w_level_reg <= w_level_reg + prod_reg[24:0];
        end
        if (cmd.goal_set)
        begin
            w_goal_reg  <= goal_new;
            w_left_reg  <= rf;
            w_mark_reg  <= qf_reg;
            div_neg_reg <= num[24];
            div_q_reg   <= num_mag[DIV_W-1:0];
            div_rem_reg <= 16'd0;
            div_cnt_reg <= DIV_CNT_W'(DIV_W);
        end
        if (cmd.div_step)
        begin
            // remainder stays below rf, so 16 bits hold it
            if (rem_sh >= {1'b0, rf})
            begin
                div_rem_reg <= rem_sh[15:0] - rf;
                div_q_reg   <= {div_q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= rem_sh[15:0];
                div_q_reg   <= {div_q_reg[DIV_W-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
        if (cmd.step_set)
            w_step_reg <= div_neg_reg ? -$signed({1'b0, div_q_reg})
                                      : $signed({1'b0, div_q_reg});
        if (cmd.out_load)
            gain_reg <= clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg      <= RAMP_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SOURCES; i++)
            begin
                level_mem[i] <= '0;
                goal_mem[i]  <= 1'b0;
                step_mem[i]  <= '0;
                left_mem[i]  <= '0;
                mark_mem[i]  <= '0;
                dead_mem[i]  <= '0;
                hold_mem[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_write_enable)
                ramp_reg <= cfg_write_data;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cmd.update)
            begin
                case (op_reg)
                    OP_RETAIN:
                    begin
                        if (hold_mem[sidx] < 7'(HOLD_MAX))
                            hold_mem[sidx] <= hold_mem[sidx] + 7'd1;
                        else
                            hold_mem[sidx] <= 7'(HOLD_MAX);
                    end
                    OP_RELEASE:
                    begin
                        hold_mem[sidx] <= hold_dec;
                        if (hold_dec == 7'd0 && until_sat > dead_mem[sidx])
                            dead_mem[sidx] <= until_sat;
                    end
                    OP_EXTEND:
                    begin
                        if (until_sat > dead_mem[sidx])
                            dead_mem[sidx] <= until_sat;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.store)
            begin
                level_mem[sidx] <= w_level_reg;
                goal_mem[sidx]  <= w_goal_reg;
                step_mem[sidx]  <= w_step_reg;
                left_mem[sidx]  <= w_left_reg;
                mark_mem[sidx]  <= w_mark_reg;
            end
        end
    end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Audition gate gain ramp testbench
// Drives random and directed requests through the gate, predicts each gain
// from a per-source model of hold count, deadline and ramp, and checks
// every returned gain in order. The ramp length is changed between phases.
// ----------------------------------------------------------------------------
module tb;
    import agr_pkg::*;

    localparam logic [47:0] FRAME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        agr_op_t     op;
        logic [4:0]  src;
        logic [47:0] qframe;
        logic [47:0] rframe;
        logic [21:0] span;
    } gate_req_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [4:0]  source_index;
    logic [47:0] query_frame;
    logic [47:0] render_frame;
    logic [21:0] span_frames;
    logic        cfg_write_enable;
    logic [15:0] cfg_write_data;
    logic        out_valid;
    logic        out_stall;
    logic [23:0] gain;

    audition_gate_gain_ramp dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .source_index     (source_index),
        .query_frame      (query_frame),
        .render_frame     (render_frame),
        .span_frames      (span_frames),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .gain             (gain)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Gate state as seen from outside, one entry per source
    logic [15:0]        ramp_len;
    logic signed [24:0] lvl     [SOURCES];
    logic               goal    [SOURCES];
    logic signed [24:0] step    [SOURCES];
    logic [15:0]        left    [SOURCES];
    logic [47:0]        mark    [SOURCES];
    logic [47:0]        until_f [SOURCES];
    logic [6:0]         holds   [SOURCES];

    gate_req_t   pending_reqs[$];
    logic [23:0] expected_gains[$];
    bit          failed;
    int unsigned idle_cycles;
    int unsigned in_gap;
    int unsigned out_gap;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_until(int s, logic [47:0] rf, logic [21:0] sp);
        logic [48:0] sum;
        logic [47:0] u;
        sum = {1'b0, rf} + 49'(sp);
        u = sum[48] ? FRAME_MAX : sum[47:0];
        if (u > until_f[s])
            until_f[s] = u;
    endfunction

    // Applies one request to the predicted gate; true when a gain comes back
    function automatic bit apply_request(gate_req_t r, output logic [23:0] g);
        int s;
        logic [47:0] el;
        logic signed [63:0] acc;
        logic new_goal;
        int signed rf;
        int signed tq;
        g = '0;
        if (r.src < 1 || r.src > SOURCES)
            return 0;
        s = r.src - 1;
        case (r.op)
            OP_RETAIN:
            begin
                if (holds[s] < HOLD_MAX)
                    holds[s] = holds[s] + 7'd1;
                return 0;
            end
            OP_RELEASE:
            begin
                if (holds[s] > 0)
                    holds[s] = holds[s] - 7'd1;
                if (holds[s] == 0)
                    push_until(s, r.rframe, r.span);
                return 0;
            end
            OP_EXTEND:
            begin
                push_until(s, r.rframe, r.span);
                return 0;
            end
            default:
            begin
                if (mark[s] == 0 && r.rframe != 0)
                    mark[s] = r.rframe;
                if (r.qframe > mark[s] && left[s] > 0)
                begin
                    el = r.qframe - mark[s];
                    if (el > 48'(left[s]))
                        el = 48'(left[s]);
                    acc = 64'(lvl[s]) + 64'(step[s]) * $signed({16'd0, el});
                    lvl[s] = acc[24:0];
                    left[s] = left[s] - el[15:0];
                    mark[s] = mark[s] + el;
                    if (left[s] == 0)
                    begin
                        lvl[s] = goal[s] ? UNITY_Q : 25'sd0;
                        step[s] = '0;
                    end
                end
                new_goal = (holds[s] > 0) || (r.qframe < until_f[s]);
                if (new_goal != goal[s])
                begin
                    rf = (ramp_len == 0) ? 1 : int'(ramp_len);
                    tq = new_goal ? int'(UNITY_Q) : 0;
                    goal[s] = new_goal;
                    left[s] = 16'(rf);
                    step[s] = 25'((tq - int'(lvl[s])) / rf);
                    mark[s] = r.qframe;
                end
                if (lvl[s] < 0)
                    g = '0;
                else if (lvl[s] > UNITY_Q)
                    g = 24'(UNITY_Q);
                else
                    g = lvl[s][23:0];
                return 1;
            end
        endcase
    endfunction

    // Driver: presents the oldest pending request, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            operation    <= OP_QUERY;
            source_index <= '0;
            query_frame  <= '0;
            render_frame <= '0;
            span_frames  <= '0;
            in_gap       <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                void'(pending_reqs.pop_front());
            if (in_valid && in_stall)
                ; // hold payload while stalled
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                in_valid     <= 1'b1;
                operation    <= pending_reqs[0].op;
                source_index <= pending_reqs[0].src;
                query_frame  <= pending_reqs[0].qframe;
                render_frame <= pending_reqs[0].rframe;
                span_frames  <= pending_reqs[0].span;
                in_gap       <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Prediction on acceptance, taken from the payload actually presented
    always @(posedge clk)
    begin
        logic [23:0] g;
        gate_req_t r;
        if (rst_n !== 1'b1)
        begin
            for (int s = 0; s < SOURCES; s++)
            begin
                lvl[s] = '0; goal[s] = 0; step[s] = '0; left[s] = '0;
                mark[s] = '0; until_f[s] = '0; holds[s] = '0;
            end
        end
        else if (in_valid && !in_stall)
        begin
            r.op     = agr_op_t'(operation);
            r.src    = source_index;
            r.qframe = query_frame;
            r.rframe = render_frame;
            r.span   = span_frames;
            if (apply_request(r, g))
                expected_gains.push_back(g);
        end
    end

    // Monitor: random stall on the gain side, compares against the oldest gain
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_gains.size() == 0)
                begin
                    $display("%0t: unexpected gain %0d", $time, gain);
                    failed = 1'b1;
                end
                else
                begin
                    if (gain !== expected_gains[0])
                    begin
                        $display("%0t: gain expected %0d actual %0d",
                                 $time, expected_gains[0], gain);
                        failed = 1'b1;
                    end
                    void'(expected_gains.pop_front());
                end
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= out_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    out_gap <= pick_gap();
            end
        end
    end

    // Watchdog: cycles without any request or gain being taken
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic gate_req_t rand_req(int unsigned flen);
        gate_req_t r;
        int unsigned k;
        k = $urandom_range(0, 99);
        r.op  = agr_op_t'((k < 50) ? OP_QUERY : $urandom_range(1, 3));
        r.src = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 4));
        r.qframe = 48'($urandom_range(0, flen));
        r.rframe = 48'($urandom_range(0, flen));
        r.span   = 22'($urandom_range(0, flen / 2));
        if ($urandom_range(0, 49) == 0)
        begin
            r.qframe = 48'({$urandom, $urandom});
            r.rframe = 48'({$urandom, $urandom});
            r.span   = 22'($urandom);
        end
        return r;
    endfunction

    task automatic drain_and_config(logic [15:0] v);
        while (pending_reqs.size() > 0 || expected_gains.size() > 0 || in_valid)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= v;
        ramp_len = v;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    function automatic gate_req_t mk(agr_op_t op, int src, logic [47:0] q,
                                     logic [47:0] rf, logic [21:0] sp);
        gate_req_t r;
        r.op = op; r.src = 5'(src); r.qframe = q; r.rframe = rf; r.span = sp;
        return r;
    endfunction

    initial
    begin
        logic [15:0] lens [6];
        int unsigned base;
        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data = '0;
        ramp_len = RAMP_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: invalid sources, hold saturation, release at zero,
        // deadline overflow, unset mark, query before mark, full ramps
        pending_reqs.push_back(mk(OP_QUERY, 0, 5, 5, 5));
        pending_reqs.push_back(mk(OP_RETAIN, 17, 0, 0, 0));
        pending_reqs.push_back(mk(OP_QUERY, 31, 1, 1, 1));
        pending_reqs.push_back(mk(OP_RELEASE, 1, 0, 100, 50));
        pending_reqs.push_back(mk(OP_QUERY, 1, 120, 100, 0));
        pending_reqs.push_back(mk(OP_QUERY, 1, 100, 0, 0));
        pending_reqs.push_back(mk(OP_QUERY, 1, 400, 0, 0));
        for (int i = 0; i < 66; i++)
            pending_reqs.push_back(mk(OP_RETAIN, 16, 0, 0, 0));
        for (int i = 0; i < 2; i++)
            pending_reqs.push_back(mk(OP_QUERY, 16, 48'(1000 * i + 5), 3, 0));
        pending_reqs.push_back(mk(OP_EXTEND, 2, 0, FRAME_MAX - 3, 22'h3FFFFF));
        pending_reqs.push_back(mk(OP_QUERY, 2, FRAME_MAX, FRAME_MAX, 22'h3FFFFF));
        pending_reqs.push_back(mk(OP_QUERY, 2, FRAME_MAX - 1, 0, 0));
        pending_reqs.push_back(mk(OP_EXTEND, 3, 0, 0, 0));
        pending_reqs.push_back(mk(OP_QUERY, 3, 0, 0, 0));

        drain_and_config(16'd0);
        lens = '{16'd1, 16'd3, 16'd17, 16'd144, 16'd65535, 16'd200};
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
                drain_and_config(lens[p]);
            base = (lens[p] > 1000) ? 200000 : 4 * lens[p] + 20;
            for (int i = 0; i < 325; i++)
                pending_reqs.push_back(rand_req(base));
        end

        while (pending_reqs.size() > 0 || expected_gains.size() > 0 || in_valid)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (!failed && expected_gains.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
